/* rtl/core/tvsr_pkg.sv */
// tvsr_pkg: widths, register indexes, bank bases and slot types of the
// texture VRAM slot resolver. No dependencies.
package tvsr_pkg;

	localparam int ADDR_W   = 19;
	localparam int LEN_W    = 22;
	localparam int OFS_W    = 20;
	localparam int END_W    = 23;
	localparam int CTRL_W   = 8;
	localparam int NUM_REGS = 7;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	localparam logic [2:0] REG_BANK_A = 3'd0;
	localparam logic [2:0] REG_BANK_B = 3'd1;
	localparam logic [2:0] REG_BANK_C = 3'd2;
	localparam logic [2:0] REG_BANK_D = 3'd3;
	localparam logic [2:0] REG_BANK_E = 3'd4;
	localparam logic [2:0] REG_BANK_F = 3'd5;
	localparam logic [2:0] REG_BANK_G = 3'd6;

	localparam int IMG_SHIFT = 17;
	localparam int PAL_SHIFT = 14;
	localparam int NUM_SLOTS = 8;

	localparam logic [8:0] IMG_MAX_SLOT = 9'd3;
	localparam logic [8:0] PAL_MAX_SLOT = 9'd5;

	localparam logic [OFS_W-1:0] IMG_SLOT_SIZE = 20'h20000;
	localparam logic [OFS_W-1:0] PAL_SLOT_SIZE = 20'h04000;
	localparam logic [OFS_W-1:0] PAL_E_BASE    = 20'h80000;
	localparam logic [OFS_W-1:0] PAL_F_BASE    = 20'h90000;
	localparam logic [OFS_W-1:0] PAL_G_BASE    = 20'h94000;

	localparam logic [OFS_W-1:0] IMG_BASE [4] = '{20'h00000, 20'h20000, 20'h40000, 20'h60000};
	localparam logic [2:0]       IMG_MODE_MASK [4] = '{3'h3, 3'h3, 3'h7, 3'h7};

	localparam logic [CTRL_W-1:0] PAL_CHECK_MASK = 8'h87;
	localparam logic [CTRL_W-1:0] PAL_CHECK_VAL  = 8'h83;
	localparam logic [2:0]        IMG_MODE_VAL   = 3'h3;

	typedef logic [CTRL_W-1:0] ctrl_t;

	typedef struct packed {
		logic             hit;
		logic [OFS_W-1:0] base;
	} slot_t;

endpackage

/* rtl/core/tvsr_if.sv */
// tvsr_req_if / tvsr_rsp_if: valid/ready channels of the slot resolver.
// Depends on tvsr_pkg.
interface tvsr_req_if import tvsr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              op;
	logic [ADDR_W-1:0] space_address;
	logic [LEN_W-1:0]  length_bytes;

	modport source (output valid, op, space_address, length_bytes, input ready);
	modport sink   (input valid, op, space_address, length_bytes, output ready);
endinterface

interface tvsr_rsp_if import tvsr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OFS_W-1:0] bank_offset;
	logic             found;

	modport source (output valid, bank_offset, found, input ready);
	modport sink   (input valid, bank_offset, found, output ready);
endinterface

/* rtl/core/texture_vram_slot_resolver.sv */
// texture_vram_slot_resolver: maps a byte run in the image or palette space
// onto a physical bank offset. Depends on tvsr_pkg and tvsr_if.
// An accepted item is registered in stage 1; its result is registered in stage 2.
// Throughput: one item per cycle while no waiting result stalls; input register, one logic stage, result register.
// A waiting result holds stage 2; stage 1 holds its item, or takes one while empty.
// Reset clears the seven bank control registers and both stage valid bits.
module texture_vram_slot_resolver import tvsr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	tvsr_req_if.sink            req,
	tvsr_rsp_if.source          rsp,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	ctrl_t ctrl_q [NUM_REGS];
	logic [2:0] reg_idx;

	logic              v_s1;
	logic              op_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [LEN_W-1:0]  len_s1;

	logic              v_s2;
	logic [OFS_W-1:0]  offset_s2;
	logic              found_s2;

	logic adv;
	logic load_s1;

	slot_t            slots [NUM_SLOTS];
	logic [LEN_W-1:0] len_m1;
	logic [END_W-1:0] end_addr;
	logic [4:0]       first_slot;
	logic [8:0]       last_slot;
	logic [8:0]       max_slot;
	logic [OFS_W-1:0] slot_size;
	logic [OFS_W-1:0] in_slot;
	logic             first_ok;
	logic             last_ok;
	logic             chain_ok;
	logic             ok;
	logic [OFS_W-1:0] offset_d;

	// Config port
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) ctrl_q[i] <= '0;
		end else if (psel && penable && pwrite && (reg_idx < 3'(NUM_REGS))) begin
			ctrl_q[reg_idx] <= pwdata[CTRL_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx < 3'(NUM_REGS)) prdata = {{(PDATA_W-CTRL_W){1'b0}}, ctrl_q[reg_idx]};
	end

	// Handshake
	assign adv       = !v_s2 || rsp.ready;
	assign req.ready = !v_s1 || adv;
	assign load_s1   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (req.ready) v_s1 <= req.valid;
			if (adv) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			op_s1   <= req.op;
			addr_s1 <= req.space_address;
			len_s1  <= req.length_bytes;
		end
		if (adv && v_s1) begin
			offset_s2 <= offset_d;
			found_s2  <= ok;
		end
	end

	// Per-slot bank resolution, lowest bank wins
	always_comb begin
		logic [1:0] ofs;
		ofs = '0;
		for (int s = 0; s < NUM_SLOTS; s++) begin
			slots[s] = '0;
			if (!op_s1) begin
				for (int b = 3; b >= 0; b--) begin
					if (ctrl_q[b][7] && ((ctrl_q[b][2:0] & IMG_MODE_MASK[b]) == IMG_MODE_VAL)
						&& (ctrl_q[b][4:3] == 2'(s)) && (s < 4)) begin
						slots[s].hit  = 1'b1;
						slots[s].base = IMG_BASE[b];
					end
				end
			end else begin
				ofs = ctrl_q[REG_BANK_G][4:3];
				if (((ctrl_q[REG_BANK_G] & PAL_CHECK_MASK) == PAL_CHECK_VAL)
					&& ({ofs[1], 1'b0, ofs[0]} == 3'(s))) begin
					slots[s].hit  = 1'b1;
					slots[s].base = PAL_G_BASE;
				end
				ofs = ctrl_q[REG_BANK_F][4:3];
				if (((ctrl_q[REG_BANK_F] & PAL_CHECK_MASK) == PAL_CHECK_VAL)
					&& ({ofs[1], 1'b0, ofs[0]} == 3'(s))) begin
					slots[s].hit  = 1'b1;
					slots[s].base = PAL_F_BASE;
				end
				if (((ctrl_q[REG_BANK_E] & PAL_CHECK_MASK) == PAL_CHECK_VAL) && (s < 4)) begin
					slots[s].hit  = 1'b1;
					slots[s].base = PAL_E_BASE | (OFS_W'(s) << PAL_SHIFT);
				end
			end
		end
	end

	// Run extent and contiguity
	always_comb begin
		len_m1    = (len_s1 == '0) ? '0 : len_s1 - 1'b1;
		end_addr  = {{(END_W-ADDR_W){1'b0}}, addr_s1} + {{(END_W-LEN_W){1'b0}}, len_m1};
		if (op_s1) begin
			first_slot = addr_s1[ADDR_W-1:PAL_SHIFT];
			last_slot  = end_addr[END_W-1:PAL_SHIFT];
			max_slot   = PAL_MAX_SLOT;
			slot_size  = PAL_SLOT_SIZE;
			in_slot    = {{(OFS_W-PAL_SHIFT){1'b0}}, addr_s1[PAL_SHIFT-1:0]};
		end else begin
			first_slot = {3'b000, addr_s1[ADDR_W-1:IMG_SHIFT]};
			last_slot  = {3'b000, end_addr[END_W-1:IMG_SHIFT]};
			max_slot   = IMG_MAX_SLOT;
			slot_size  = IMG_SLOT_SIZE;
			in_slot    = {{(OFS_W-IMG_SHIFT){1'b0}}, addr_s1[IMG_SHIFT-1:0]};
		end
		first_ok = (first_slot < 5'(NUM_SLOTS)) && slots[first_slot[2:0]].hit;
		last_ok  = last_slot <= max_slot;
		chain_ok = 1'b1;
		for (int s = 1; s < NUM_SLOTS; s++) begin
			if ((5'(s) > first_slot) && (9'(s) <= last_slot)
				&& !(slots[s].hit && (slots[s].base == slots[s-1].base + slot_size)))
				chain_ok = 1'b0;
		end
		ok       = first_ok && last_ok && chain_ok;
		offset_d = ok ? slots[first_slot[2:0]].base + in_slot : '0;
	end

	assign rsp.valid       = v_s2;
	assign rsp.bank_offset = offset_s2;
	assign rsp.found       = found_s2;

endmodule

/* rtl/core/tvsr_checker.sv */
// tvsr_checker: port-level checks of the slot resolver, bound to texture_vram_slot_resolver.
// Depends on tvsr_pkg.
module tvsr_checker import tvsr_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [OFS_W-1:0] bank_offset,
	input logic             found,
	input logic             pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bank_offset) && $stable(found))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> bank_offset == '0)
		else $error("offset nonzero on miss");

	a_ofs_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> bank_offset <= 20'h97FFF)
		else $error("offset out of range");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without item");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind texture_vram_slot_resolver tvsr_checker u_tvsr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.bank_offset (rsp.bank_offset),
	.found       (rsp.found),
	.pready      (pready)
);
